[design/blm_pkg.sv]
// ----------------------------------------------------------------------------
// blm_pkg
// Shared widths, constants, codes and types of the backlight level mapper.
// ----------------------------------------------------------------------------
package blm_pkg;

	localparam int LEVEL_W    = 9;
	localparam int PWM_W      = 12;
	localparam int SLOPE_W    = 16;
	localparam int OFFSET_W   = 8;
	localparam int PROD_W     = OFFSET_W + SLOPE_W;
	localparam int HIGH_W     = 8;
	localparam int LOW_W      = 4;
	localparam int KIND_W     = 2;
	localparam int CMD_W      = 2;
	localparam int Q_SHIFT    = 10;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam int LEVEL_MAX     = 255;
	localparam int LEVEL_DEFAULT = 125;
	localparam int LEVEL_MIN     = 2;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [PWM_W-1:0]   OUTDOOR_PWM_RST   = 12'd3976;
	localparam logic [PWM_W-1:0]   DEFAULT_PWM_RST   = 12'd1200;
	localparam logic [PWM_W-1:0]   MINIMUM_PWM_RST   = 12'd32;
	localparam logic [SLOPE_W-1:0] UPPER_SLOPE_RST   = 16'd15998;
	localparam logic [SLOPE_W-1:0] LOWER_SLOPE_RST   = 16'd9723;
	localparam logic [LEVEL_W-1:0] DIMMING_TH_RST    = 9'd14;
	localparam logic [LEVEL_W-1:0] CABC_TH_RST       = 9'd60;

	typedef enum logic [KIND_W-1:0] {
		KIND_LEVEL     = 2'd0,
		KIND_BOOST     = 2'd1,
		KIND_PANEL_OFF = 2'd2,
		KIND_SPARE     = 2'd3
	} kind_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_NONE = 2'd0,
		CMD_ON   = 2'd1,
		CMD_OFF  = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		SEG_ZERO    = 2'd0,
		SEG_LOWER   = 2'd1,
		SEG_UPPER   = 2'd2,
		SEG_OUTDOOR = 2'd3
	} seg_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_OUTDOOR_PWM = 3'd0,
		CFG_DEFAULT_PWM = 3'd1,
		CFG_MINIMUM_PWM = 3'd2,
		CFG_UPPER_SLOPE = 3'd3,
		CFG_LOWER_SLOPE = 3'd4,
		CFG_DIMMING_TH  = 3'd5,
		CFG_CABC_TH     = 3'd6
	} cfg_index_t;

	typedef struct packed {
		logic [PWM_W-1:0]   outdoor_pwm;
		logic [PWM_W-1:0]   default_pwm;
		logic [PWM_W-1:0]   minimum_pwm;
		logic [SLOPE_W-1:0] upper_slope;
		logic [SLOPE_W-1:0] lower_slope;
		logic [LEVEL_W-1:0] dimming_th;
		logic [LEVEL_W-1:0] cabc_th;
	} cfg_t;

	typedef struct packed {
		seg_t                segment;
		logic [OFFSET_W-1:0] offset;
		logic                dimming_on;
		logic                cabc_on;
		logic                hook_armed;
		cmd_t                cmd;
	} entry_t;

endpackage

[design/blm_if.sv]
// ----------------------------------------------------------------------------
// blm_in_if / blm_out_if
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface blm_in_if;
	logic                         valid;
	logic                         ready;
	logic [blm_pkg::KIND_W-1:0]   kind;
	logic [blm_pkg::LEVEL_W-1:0]  brightness_level;
	logic                         display_on_pending;
	logic                         boost_enable;

	modport source (output valid, kind, brightness_level, display_on_pending, boost_enable,
		input ready);
	modport sink (input valid, kind, brightness_level, display_on_pending, boost_enable,
		output ready);
endinterface

interface blm_out_if;
	logic                        valid;
	logic                        ready;
	logic [blm_pkg::HIGH_W-1:0]  pwm_code_high;
	logic [blm_pkg::LOW_W-1:0]   pwm_code_low;
	logic                        dimming_on;
	logic                        cabc_on;
	logic                        boost_hook_armed;
	logic [blm_pkg::CMD_W-1:0]   boost_command;

	modport source (output valid, pwm_code_high, pwm_code_low, dimming_on, cabc_on,
		boost_hook_armed, boost_command, input ready);
	modport sink (input valid, pwm_code_high, pwm_code_low, dimming_on, cabc_on,
		boost_hook_armed, boost_command, output ready);
endinterface

[design/backlight_level_to_pwm_mapper.sv]
// ----------------------------------------------------------------------------
// backlight_level_to_pwm_mapper
// Maps backlight levels to 12-bit PWM codes and drives boost early-off control.
// ----------------------------------------------------------------------------
// Takes one transaction per clock while the result channel is not stalled,
// and returns one result per transaction, in order. The front part updates
// the boost state in the cycle a transaction is accepted and classifies the
// level; a queue of QUEUE_DEPTH entries follows, then a two-stage back part
// (one 8x16 slope multiply, then the base add and output register). A result
// passes through the queue, the multiply stage and the output register.
// Configuration is to be written only while idle (not enforced by the block).
module backlight_level_to_pwm_mapper #(
	parameter int QUEUE_DEPTH = blm_pkg::QUEUE_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	blm_in_if.sink                           item,
	blm_out_if.source                        result,
	input  logic                             cfg_wr_en,
	input  logic [blm_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [blm_pkg::CFG_DATA_W-1:0]   cfg_data
);

	blm_pkg::cfg_t   cfg;
	logic            push_valid;
	logic            push_ready;
	blm_pkg::entry_t push_data;
	logic            pop_valid;
	logic            pop_ready;
	blm_pkg::entry_t pop_data;

	blm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	blm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.cfg        (cfg),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	blm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	blm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data),
		.result    (result)
	);

endmodule

[design/blm_cfg.sv]
// ----------------------------------------------------------------------------
// blm_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module blm_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [blm_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [blm_pkg::CFG_DATA_W-1:0]   cfg_data,
	output blm_pkg::cfg_t                    cfg
);

	blm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.outdoor_pwm <= blm_pkg::OUTDOOR_PWM_RST;
			cfg_q.default_pwm <= blm_pkg::DEFAULT_PWM_RST;
			cfg_q.minimum_pwm <= blm_pkg::MINIMUM_PWM_RST;
			cfg_q.upper_slope <= blm_pkg::UPPER_SLOPE_RST;
			cfg_q.lower_slope <= blm_pkg::LOWER_SLOPE_RST;
			cfg_q.dimming_th  <= blm_pkg::DIMMING_TH_RST;
			cfg_q.cabc_th     <= blm_pkg::CABC_TH_RST;
		end else if (cfg_wr_en) begin
			unique case (blm_pkg::cfg_index_t'(cfg_index))
				blm_pkg::CFG_OUTDOOR_PWM: cfg_q.outdoor_pwm <= cfg_data[blm_pkg::PWM_W-1:0];
				blm_pkg::CFG_DEFAULT_PWM: cfg_q.default_pwm <= cfg_data[blm_pkg::PWM_W-1:0];
				blm_pkg::CFG_MINIMUM_PWM: cfg_q.minimum_pwm <= cfg_data[blm_pkg::PWM_W-1:0];
				blm_pkg::CFG_UPPER_SLOPE: cfg_q.upper_slope <= cfg_data[blm_pkg::SLOPE_W-1:0];
				blm_pkg::CFG_LOWER_SLOPE: cfg_q.lower_slope <= cfg_data[blm_pkg::SLOPE_W-1:0];
				blm_pkg::CFG_DIMMING_TH:  cfg_q.dimming_th  <= cfg_data[blm_pkg::LEVEL_W-1:0];
				blm_pkg::CFG_CABC_TH:     cfg_q.cabc_th     <= cfg_data[blm_pkg::LEVEL_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[design/blm_front.sv]
// ----------------------------------------------------------------------------
// blm_front
// Accepts transactions, keeps the boost early-off state and classifies each
// level into a segment with its offset for the back part.
// ----------------------------------------------------------------------------
module blm_front (
	input  logic                 clk,
	input  logic                 arst_n,
	blm_in_if.sink               item,
	input  blm_pkg::cfg_t        cfg,
	output logic                 push_valid,
	input  logic                 push_ready,
	output blm_pkg::entry_t      push_data
);

	logic [blm_pkg::LEVEL_W-1:0] prev_level_q;
	logic                        boost_off_q;
	logic                        hook_armed_q;

	logic [blm_pkg::LEVEL_W-1:0] prev_level_d;
	logic                        boost_off_d;
	logic                        hook_armed_d;
	logic                        accept;
	logic [blm_pkg::LEVEL_W-1:0] level;
	blm_pkg::entry_t             entry;

	assign item.ready = push_ready;
	assign push_valid = item.valid;
	assign accept     = item.valid && push_ready;
	assign level      = item.brightness_level;

	always_comb begin
		prev_level_d     = prev_level_q;
		boost_off_d      = boost_off_q;
		hook_armed_d     = hook_armed_q;
		entry            = '0;
		entry.segment    = blm_pkg::SEG_ZERO;
		entry.cmd        = blm_pkg::CMD_NONE;
		unique case (blm_pkg::kind_t'(item.kind))
			blm_pkg::KIND_LEVEL: begin
				if (level > blm_pkg::LEVEL_W'(blm_pkg::LEVEL_MAX)) begin
					entry.segment = blm_pkg::SEG_OUTDOOR;
				end else if (level > blm_pkg::LEVEL_W'(blm_pkg::LEVEL_DEFAULT)) begin
					entry.segment = blm_pkg::SEG_UPPER;
					entry.offset  = blm_pkg::OFFSET_W'(level -
						blm_pkg::LEVEL_W'(blm_pkg::LEVEL_DEFAULT));
				end else if (level >= blm_pkg::LEVEL_W'(blm_pkg::LEVEL_MIN)) begin
					// level 2 lands on the lower segment with a zero offset
					entry.segment = blm_pkg::SEG_LOWER;
					entry.offset  = blm_pkg::OFFSET_W'(level -
						blm_pkg::LEVEL_W'(blm_pkg::LEVEL_MIN));
				end
				entry.dimming_on = level > cfg.dimming_th;
				entry.cabc_on    = level > cfg.cabc_th;
				if (level == '0 && !item.display_on_pending) begin
					hook_armed_d = prev_level_q != '0;
				end
				if (level != '0 && prev_level_q == '0 && boost_off_q && hook_armed_d) begin
					boost_off_d = 1'b0;
					entry.cmd   = blm_pkg::CMD_ON;
				end
				prev_level_d = level;
			end
			blm_pkg::KIND_BOOST: begin
				boost_off_d = !item.boost_enable;
				entry.cmd   = item.boost_enable ? blm_pkg::CMD_ON : blm_pkg::CMD_OFF;
			end
			blm_pkg::KIND_PANEL_OFF: begin
				prev_level_d = '0;
				boost_off_d  = 1'b0;
			end
			default: ;
		endcase
		entry.hook_armed = hook_armed_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q <= '0;
			boost_off_q  <= 1'b0;
			hook_armed_q <= 1'b1;
		end else if (accept) begin
			prev_level_q <= prev_level_d;
			boost_off_q  <= boost_off_d;
			hook_armed_q <= hook_armed_d;
		end
	end

	assign push_data = entry;

endmodule

[design/blm_queue.sv]
// ----------------------------------------------------------------------------
// blm_queue
// Short first-in first-out queue between the front and the back part.
// ----------------------------------------------------------------------------
module blm_queue #(
	parameter int DEPTH = blm_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  blm_pkg::entry_t push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output blm_pkg::entry_t pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	blm_pkg::entry_t  mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[design/blm_back.sv]
// ----------------------------------------------------------------------------
// blm_back
// Computes the PWM code from the classified entry: slope multiply in the
// first stage, base add and result formatting in the output stage.
// ----------------------------------------------------------------------------
module blm_back (
	input  logic            clk,
	input  logic            arst_n,
	input  blm_pkg::cfg_t   cfg,
	input  logic            pop_valid,
	output logic            pop_ready,
	input  blm_pkg::entry_t pop_data,
	blm_out_if.source       result
);

	logic                       valid_s1;
	blm_pkg::entry_t            entry_s1;
	logic [blm_pkg::PROD_W-1:0] prod_s1;

	logic                       valid_s2;
	logic [blm_pkg::PWM_W-1:0]  code_s2;
	logic                       dimming_s2;
	logic                       cabc_s2;
	logic                       hook_s2;
	blm_pkg::cmd_t              cmd_s2;

	logic                        adv_s2;
	logic                        adv_s1;
	logic [blm_pkg::SLOPE_W-1:0] slope;
	logic [blm_pkg::PWM_W-1:0]   base;
	logic [blm_pkg::PWM_W-1:0]   code;

	assign adv_s2    = !valid_s2 || result.ready;
	assign adv_s1    = !valid_s1 || adv_s2;
	assign pop_ready = adv_s1;

	assign slope = (pop_data.segment == blm_pkg::SEG_UPPER) ? cfg.upper_slope
		: cfg.lower_slope;

	always_comb begin
		unique case (entry_s1.segment)
			blm_pkg::SEG_ZERO:    base = '0;
			blm_pkg::SEG_LOWER:   base = cfg.minimum_pwm;
			blm_pkg::SEG_UPPER:   base = cfg.default_pwm;
			blm_pkg::SEG_OUTDOOR: base = cfg.outdoor_pwm;
			default:              base = '0;
		endcase
	end

	assign code = prod_s1[blm_pkg::Q_SHIFT +: blm_pkg::PWM_W] + base;

	always_ff @(posedge clk) begin
		if (adv_s1 && pop_valid) begin
			entry_s1 <= pop_data;
			prod_s1  <= blm_pkg::PROD_W'(pop_data.offset * slope);
		end
		if (adv_s2 && valid_s1) begin
			code_s2    <= code;
			dimming_s2 <= entry_s1.dimming_on;
			cabc_s2    <= entry_s1.cabc_on;
			hook_s2    <= entry_s1.hook_armed;
			cmd_s2     <= entry_s1.cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= pop_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	assign result.valid            = valid_s2;
	assign result.pwm_code_high    = code_s2[blm_pkg::LOW_W +: blm_pkg::HIGH_W];
	assign result.pwm_code_low     = code_s2[blm_pkg::LOW_W-1:0];
	assign result.dimming_on       = dimming_s2;
	assign result.cabc_on          = cabc_s2;
	assign result.boost_hook_armed = hook_s2;
	assign result.boost_command    = cmd_s2;

endmodule

[design/blm_checker.sv]
// ----------------------------------------------------------------------------
// blm_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module blm_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         res_valid,
	input logic                         res_ready,
	input logic [blm_pkg::HIGH_W-1:0]   res_pwm_code_high,
	input logic [blm_pkg::LOW_W-1:0]    res_pwm_code_low,
	input logic                         res_dimming_on,
	input logic                         res_cabc_on,
	input logic                         res_boost_hook_armed,
	input logic [blm_pkg::CMD_W-1:0]    res_boost_command
);

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result valid dropped while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_pwm_code_high) && $stable(res_pwm_code_low)
			&& $stable(res_boost_hook_armed) && $stable(res_boost_command))
		else $error("result payload changed while stalled");

	a_off_no_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_boost_command == blm_pkg::CMD_OFF |->
			res_pwm_code_high == '0 && res_pwm_code_low == '0
			&& !res_dimming_on && !res_cabc_on)
		else $error("boost off transaction carries a pwm code");

	a_cmd_legal: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_boost_command == blm_pkg::CMD_NONE
			|| res_boost_command == blm_pkg::CMD_ON
			|| res_boost_command == blm_pkg::CMD_OFF)
		else $error("undefined boost command");

endmodule

bind backlight_level_to_pwm_mapper blm_checker u_blm_checker (
	.clk                  (clk),
	.arst_n               (arst_n),
	.res_valid            (result.valid),
	.res_ready            (result.ready),
	.res_pwm_code_high    (result.pwm_code_high),
	.res_pwm_code_low     (result.pwm_code_low),
	.res_dimming_on       (result.dimming_on),
	.res_cabc_on          (result.cabc_on),
	.res_boost_hook_armed (result.boost_hook_armed),
	.res_boost_command    (result.boost_command)
);

[test/backlight_level_to_pwm_mapper_tb.sv]
// ----------------------------------------------------------------------------
// backlight_level_to_pwm_mapper_tb
// Self-checking bench for the backlight level to PWM code mapper.
// ----------------------------------------------------------------------------
// Drives brightness updates, boost requests, panel-off events and spare items
// through the valid/ready input channel and predicts every result in order:
// the piecewise-linear PWM code, dimming and CABC flags, early-off hook state
// and boost command. Results are compared field by field as they leave the
// result channel. Runs a directed sequence on reset settings, then random
// phases under all-ones, all-zero, reset and random register settings, with
// random idling on both channels, a long result hold-off and a full drain.
// ----------------------------------------------------------------------------
module backlight_level_to_pwm_mapper_tb;

	import blm_pkg::*;

	localparam int NUM_REGS      = 7;
	localparam int PHASE_ITEMS   = 80;
	localparam int NUM_PHASES    = 6;
	localparam int HOLD_CYCLES   = 60;
	localparam int SETTLE_CYCLES = 4;
	localparam int STALL_LIMIT   = 2000;

	typedef struct packed {
		logic [HIGH_W-1:0] code_high;
		logic [LOW_W-1:0]  code_low;
		logic              dimming;
		logic              cabc;
		logic              hook;
		cmd_t              cmd;
	} outcome_t;

	class backlight_outcomes;
		cfg_t               regs;
		logic [LEVEL_W-1:0] prev_level;
		bit                 boost_off;
		bit                 hook_armed;
		outcome_t           pending_outcomes[$];
		int                 mismatches;

		function new();
			regs.outdoor_pwm = OUTDOOR_PWM_RST;
			regs.default_pwm = DEFAULT_PWM_RST;
			regs.minimum_pwm = MINIMUM_PWM_RST;
			regs.upper_slope = UPPER_SLOPE_RST;
			regs.lower_slope = LOWER_SLOPE_RST;
			regs.dimming_th  = DIMMING_TH_RST;
			regs.cabc_th     = CABC_TH_RST;
			prev_level = '0;
			boost_off  = 1'b0;
			hook_armed = 1'b1;
			mismatches = 0;
		endfunction

		function void write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_OUTDOOR_PWM: regs.outdoor_pwm = data[PWM_W-1:0];
				CFG_DEFAULT_PWM: regs.default_pwm = data[PWM_W-1:0];
				CFG_MINIMUM_PWM: regs.minimum_pwm = data[PWM_W-1:0];
				CFG_UPPER_SLOPE: regs.upper_slope = data[SLOPE_W-1:0];
				CFG_LOWER_SLOPE: regs.lower_slope = data[SLOPE_W-1:0];
				CFG_DIMMING_TH:  regs.dimming_th  = data[LEVEL_W-1:0];
				CFG_CABC_TH:     regs.cabc_th     = data[LEVEL_W-1:0];
				default: ;
			endcase
		endfunction

		function outcome_t map_item(kind_t k, logic [LEVEL_W-1:0] level, logic pending,
				logic enable);
			outcome_t o;
			logic [31:0] code;
			o = '0;
			o.cmd = CMD_NONE;
			code = '0;
			case (k)
				KIND_LEVEL: begin
					if (level > LEVEL_MAX)
						code = 32'(regs.outdoor_pwm);
					else if (level > LEVEL_DEFAULT)
						code = (((32'(level) - 32'(LEVEL_DEFAULT)) * 32'(regs.upper_slope))
							>> Q_SHIFT) + 32'(regs.default_pwm);
					else if (level > LEVEL_MIN)
						code = (((32'(level) - 32'(LEVEL_MIN)) * 32'(regs.lower_slope))
							>> Q_SHIFT) + 32'(regs.minimum_pwm);
					else if (level == LEVEL_MIN)
						code = 32'(regs.minimum_pwm);
					o.dimming = level > regs.dimming_th;
					o.cabc = level > regs.cabc_th;
					if (level == 0 && !pending)
						hook_armed = prev_level != 0;
					if (level != 0 && prev_level == 0 && boost_off && hook_armed) begin
						boost_off = 1'b0;
						o.cmd = CMD_ON;
					end
					prev_level = level;
				end
				KIND_BOOST: begin
					boost_off = !enable;
					o.cmd = enable ? CMD_ON : CMD_OFF;
				end
				KIND_PANEL_OFF: begin
					prev_level = '0;
					boost_off = 1'b0;
				end
				default: ;
			endcase
			o.code_high = code[11:4];
			o.code_low = code[3:0];
			o.hook = hook_armed;
			return o;
		endfunction

		function void note_item(kind_t k, logic [LEVEL_W-1:0] level, logic pending,
				logic enable);
			pending_outcomes.push_back(map_item(k, level, pending, enable));
		endfunction

		function int outstanding();
			return pending_outcomes.size();
		endfunction

		task report(string msg);
			$display("mismatch at %0t: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_outcome(outcome_t got);
			outcome_t want;
			if (pending_outcomes.size() == 0) begin
				report("result with no transaction waiting");
				return;
			end
			want = pending_outcomes.pop_front();
			if (got.code_high !== want.code_high)
				report($sformatf("pwm_code_high %0h expected %0h", got.code_high, want.code_high));
			if (got.code_low !== want.code_low)
				report($sformatf("pwm_code_low %0h expected %0h", got.code_low, want.code_low));
			if (got.dimming !== want.dimming)
				report($sformatf("dimming_on %b expected %b", got.dimming, want.dimming));
			if (got.cabc !== want.cabc)
				report($sformatf("cabc_on %b expected %b", got.cabc, want.cabc));
			if (got.hook !== want.hook)
				report($sformatf("boost_hook_armed %b expected %b", got.hook, want.hook));
			if (got.cmd !== want.cmd)
				report($sformatf("boost_command %0d expected %0d", got.cmd, want.cmd));
		endtask
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	logic [CFG_DATA_W-1:0]  reg_vals [NUM_REGS];
	bit                     idle_on;
	bit                     hold_req;
	int                     stall_cycles;
	backlight_outcomes      book;

	blm_in_if  item_ch ();
	blm_out_if result_ch ();

	backlight_level_to_pwm_mapper uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.result    (result_ch),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic send_item(kind_t k, logic [LEVEL_W-1:0] level, logic pending,
			logic enable);
		if (idle_on && $urandom_range(99) < 17) begin
			item_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.kind <= k;
		item_ch.brightness_level <= level;
		item_ch.display_on_pending <= pending;
		item_ch.boost_enable <= enable;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		book.note_item(k, level, pending, enable);
	endtask

	function automatic logic [LEVEL_W-1:0] pick_level();
		int sel;
		sel = $urandom_range(9);
		if (sel < 3)
			return '0;
		if (sel == 3)
			case ($urandom_range(7))
				0: return LEVEL_W'(1);
				1: return LEVEL_W'(LEVEL_MIN);
				2: return LEVEL_W'(LEVEL_MIN + 1);
				3: return LEVEL_W'(LEVEL_DEFAULT);
				4: return LEVEL_W'(LEVEL_DEFAULT + 1);
				5: return LEVEL_W'(LEVEL_MAX);
				6: return LEVEL_W'(LEVEL_MAX + 1);
				default: return '1;
			endcase
		return LEVEL_W'($urandom_range(0, 511));
	endfunction

	task automatic random_item();
		int r;
		kind_t k;
		r = $urandom_range(99);
		if (r < 65)
			k = KIND_LEVEL;
		else if (r < 80)
			k = KIND_BOOST;
		else if (r < 92)
			k = KIND_PANEL_OFF;
		else
			k = KIND_SPARE;
		send_item(k, pick_level(), $urandom_range(3) == 0, 1'($urandom_range(1)));
	endtask

	// boost off, light up, dark (arming early-off unless display-on is pending), then light up again
	task automatic boost_recover_burst();
		send_item(KIND_BOOST, pick_level(), 1'($urandom_range(1)), 1'b0);
		send_item(KIND_LEVEL, LEVEL_W'($urandom_range(1, 511)), 1'($urandom_range(1)),
			1'($urandom_range(1)));
		send_item(KIND_LEVEL, '0, 1'($urandom_range(3) == 0), 1'($urandom_range(1)));
		send_item(KIND_LEVEL, LEVEL_W'($urandom_range(1, 511)), 1'($urandom_range(1)),
			1'($urandom_range(1)));
	endtask

	task automatic drain();
		item_ch.valid <= 1'b0;
		while (book.outstanding() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic program_regs();
		cfg_index_t idx;
		idx = idx.first();
		do begin
			cfg_wr_en <= 1'b1;
			cfg_index <= idx;
			cfg_data <= reg_vals[idx];
			book.write_reg(idx, reg_vals[idx]);
			@(posedge clk);
			idx = idx.next();
		end while (idx != idx.first());
		cfg_wr_en <= 1'b0;
	endtask

	// result side: random stalls, one long hold-off on request
	initial begin
		result_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				result_ch.ready <= !idle_on || ($urandom_range(99) >= 17);
			end
		end
	end

	always @(posedge clk) begin
		outcome_t got;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.code_high = result_ch.pwm_code_high;
			got.code_low = result_ch.pwm_code_low;
			got.dimming = result_ch.dimming_on;
			got.cabc = result_ch.cabc_on;
			got.hook = result_ch.boost_hook_armed;
			got.cmd = cmd_t'(result_ch.boost_command);
			book.check_outcome(got);
		end
	end

	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		book = new();
		stall_cycles = 0;
		idle_on = 1'b1;
		hold_req = 1'b0;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		item_ch.valid = 1'b0;
		item_ch.kind = KIND_LEVEL;
		item_ch.brightness_level = '0;
		item_ch.display_on_pending = 1'b0;
		item_ch.boost_enable = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part on reset settings
		send_item(KIND_LEVEL, '0, 1'b0, 1'b0);
		send_item(KIND_BOOST, '0, 1'b0, 1'b0);
		send_item(KIND_LEVEL, LEVEL_W'(LEVEL_MIN), 1'b0, 1'b0);
		send_item(KIND_LEVEL, '0, 1'b0, 1'b0);
		send_item(KIND_LEVEL, LEVEL_W'(LEVEL_DEFAULT), 1'b0, 1'b0);
		send_item(KIND_BOOST, '1, 1'b1, 1'b1);
		send_item(KIND_BOOST, '0, 1'b0, 1'b0);
		send_item(KIND_PANEL_OFF, '1, 1'b1, 1'b1);
		send_item(KIND_LEVEL, LEVEL_W'(LEVEL_DEFAULT + 1), 1'b0, 1'b0);
		send_item(KIND_LEVEL, LEVEL_W'(LEVEL_MAX), 1'b1, 1'b1);
		send_item(KIND_LEVEL, LEVEL_W'(LEVEL_MAX + 1), 1'b0, 1'b0);
		send_item(KIND_LEVEL, '1, 1'b0, 1'b1);
		send_item(KIND_LEVEL, LEVEL_W'(1), 1'b0, 1'b0);
		send_item(KIND_LEVEL, LEVEL_W'(LEVEL_MIN + 1), 1'b0, 1'b0);
		send_item(KIND_LEVEL, LEVEL_W'(DIMMING_TH_RST), 1'b0, 1'b0);
		send_item(KIND_LEVEL, LEVEL_W'(DIMMING_TH_RST + 1), 1'b0, 1'b0);
		send_item(KIND_LEVEL, LEVEL_W'(CABC_TH_RST), 1'b0, 1'b0);
		send_item(KIND_LEVEL, LEVEL_W'(CABC_TH_RST + 1), 1'b0, 1'b0);
		send_item(KIND_SPARE, '1, 1'b1, 1'b1);
		send_item(KIND_BOOST, '1, 1'b1, 1'b0);
		send_item(KIND_LEVEL, '0, 1'b1, 1'b0);
		send_item(KIND_LEVEL, LEVEL_W'(LEVEL_DEFAULT), 1'b0, 1'b0);
		send_item(KIND_LEVEL, '0, 1'b0, 1'b0);

		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			drain();
			for (int i = 0; i < NUM_REGS; i++)
				case (phase)
					0: reg_vals[i] = '1;
					1: reg_vals[i] = '0;
					default: reg_vals[i] = CFG_DATA_W'($urandom_range(0, 65535));
				endcase
			if (phase == 2) begin
				reg_vals[CFG_OUTDOOR_PWM] = CFG_DATA_W'(OUTDOOR_PWM_RST);
				reg_vals[CFG_DEFAULT_PWM] = CFG_DATA_W'(DEFAULT_PWM_RST);
				reg_vals[CFG_MINIMUM_PWM] = CFG_DATA_W'(MINIMUM_PWM_RST);
				reg_vals[CFG_UPPER_SLOPE] = UPPER_SLOPE_RST;
				reg_vals[CFG_LOWER_SLOPE] = LOWER_SLOPE_RST;
				reg_vals[CFG_DIMMING_TH] = CFG_DATA_W'(DIMMING_TH_RST);
				reg_vals[CFG_CABC_TH] = CFG_DATA_W'(CABC_TH_RST);
			end
			program_regs();
			idle_on = phase != 3;
			if (phase == 1)
				hold_req = 1'b1;
			for (int n = 0; n < PHASE_ITEMS; ) begin
				if (phase == 4 && n == PHASE_ITEMS / 2)
					drain();
				if ($urandom_range(99) < 15) begin
					boost_recover_burst();
					n += 4;
				end else begin
					random_item();
					n++;
				end
			end
		end

		drain();
		if (book.mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
